// ----- rtl/core/dtq_pkg.sv -----
// Shared constants, codes and types of the deadline timer queue.
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

    localparam int CAPACITY    = 16;
    localparam int HANDLE_BITS = 8;
    localparam int MAX_RESULTS = 16;

    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 16;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 2;

    // Width of a stored handle: the masked handle never has more bits than the field.
    localparam int HB_ST = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int NRES_W = $clog2(MAX_RESULTS + 1);

    localparam logic REQ_ARM  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ARMED     = 2'd0,
        ST_FULL      = 2'd1,
        ST_FIRED     = 2'd2,
        ST_NONE_DUE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_INSERT,
        S_RESP,
        S_POP
    } t_state;

    // Commands from the sequencer to the sorted entry store.
    typedef struct packed {
        logic             ins;
        logic             pop;
        logic [CNT_W-1:0] pos;
        logic [PTR_W-1:0] rd_idx;
    } t_store_ctl;

endpackage

`default_nettype wire

// ----- rtl/core/dtq_if.sv -----
// Handshake channels of the deadline timer queue: request in, result out.
`timescale 1ns / 1ps
`default_nettype none

interface dtq_req_if;
    import dtq_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [DELAY_W-1:0]  delay_ticks;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output req_type, output delay_ticks, output handle,
                    input ready);
    modport sink   (input valid, input req_type, input delay_ticks, input handle,
                    output ready);
endinterface

interface dtq_rsp_if;
    import dtq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] fired_handle;
    logic                last;

    modport source (output valid, output status, output fired_handle, output last,
                    input ready);
    modport sink   (input valid, input status, input fired_handle, input last,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/deadline_timer_queue.sv -----
// Top level of the deadline timer queue: sequencer, tick count and shared comparator.
//
// Requests arrive on i_req and results leave on o_rsp, both valid/ready channels.
// An arm request (req_type 0) stores deadline = now + delay_ticks with its handle
// and returns one result: armed, or rejected when all CAPACITY entries are in use.
// A tick request (req_type 1) advances the count by one and returns one result per
// expired entry, earliest first and at most MAX_RESULTS, or a single "nothing due"
// result; the final result of a request carries last = 1.
// One wrap-aware comparator walks the sorted store. An arm walks past the entries
// at or before its deadline (at most count), is inserted behind them and then
// loads its result; a rejected arm skips the walk and goes straight to its result.
// A tick pops its expired entries from the head, each popped handle giving a result.
// i_req.ready is high only while no request is in work, so the next request is
// taken no earlier than the last result of the previous one becomes valid.
// A stalled receiver holds the result register, and the pops of a tick wait with it.
// Reset clears the tick count, the entry count and the result valid flag; the store
// contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module deadline_timer_queue (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dtq_req_if.sink   i_req,
    dtq_rsp_if.source o_rsp
);
    import dtq_pkg::*;

    t_state             r_state, n_state;
    logic [TIME_W-1:0]  r_time;
    logic [TIME_W-1:0]  r_dl;
    logic [HB_ST-1:0]   r_new_handle;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_ptr;
    logic [NRES_W-1:0]  r_nres;
    logic               r_have_pend;
    logic [HB_ST-1:0]   r_pend;
    t_status            r_resp;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [HB_ST-1:0]   r_out_handle;
    logic               r_out_last;

    t_store_ctl         store_ctl;
    logic [TIME_W-1:0]  head_deadline;
    logic [HB_ST-1:0]   head_handle;
    logic [TIME_W-1:0]  rd_deadline;

    logic [TIME_W-1:0]  cmp_a, cmp_b, cmp_diff;
    logic               cmp_le;
    logic               accept, out_free;
    logic               fire, search_go;
    logic               out_load;
    t_status            out_status;
    logic [HB_ST-1:0]   out_handle;
    logic               out_last;

    dtq_store u_store (
        .i_clk           (i_clk),
        .i_ctl           (store_ctl),
        .i_deadline      (r_dl),
        .i_handle        (r_new_handle),
        .o_head_deadline (head_deadline),
        .o_head_handle   (head_handle),
        .o_rd_deadline   (rd_deadline)
    );

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // Shared comparator: a is at or before b when b - a has a clear sign bit.
    always_comb begin
        if (r_state == S_POP) begin
            cmp_a = head_deadline;
            cmp_b = r_time;
        end else begin
            cmp_a = rd_deadline;
            cmp_b = r_dl;
        end
        cmp_diff = cmp_b - cmp_a;
        cmp_le   = !cmp_diff[TIME_W-1];
    end

    assign search_go = (r_ptr < r_count) && cmp_le;
    assign fire      = (r_count != '0) && (r_nres != NRES_W'(MAX_RESULTS)) && cmp_le;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == REQ_TICK) begin
                        n_state = S_POP;
                    end else if (r_count == CNT_W'(CAPACITY)) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (!search_go) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free && !fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        store_ctl.ins    = 1'b0;
        store_ctl.pop    = 1'b0;
        store_ctl.pos    = r_ptr;
        store_ctl.rd_idx = r_ptr[PTR_W-1:0];
        out_load         = 1'b0;
        out_status       = ST_NONE_DUE;
        out_handle       = '0;
        out_last         = 1'b1;
        unique case (r_state)
            S_IDLE:   ;
            S_SEARCH: ;
            S_INSERT: store_ctl.ins = 1'b1;
            S_RESP: begin
                out_load   = out_free;
                out_status = r_resp;
            end
            S_POP: begin
                if (out_free) begin
                    if (fire) begin
                        store_ctl.pop = 1'b1;
                        out_load      = r_have_pend;
                        out_status    = ST_FIRED;
                        out_handle    = r_pend;
                        out_last      = 1'b0;
                    end else begin
                        out_load = 1'b1;
                        if (r_have_pend) begin
                            out_status = ST_FIRED;
                            out_handle = r_pend;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_have_pend <= 1'b0;
            r_ptr       <= '0;
            r_nres      <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_ptr       <= '0;
                    r_nres      <= '0;
                    r_have_pend <= 1'b0;
                    if (accept && (i_req.req_type == REQ_TICK)) begin
                        r_time <= r_time + TIME_W'(1);
                    end
                end
                S_SEARCH: begin
                    if (search_go) begin
                        r_ptr <= r_ptr + CNT_W'(1);
                    end
                end
                S_INSERT: r_count <= r_count + CNT_W'(1);
                S_RESP:   ;
                S_POP: begin
                    if (out_free && fire) begin
                        r_count     <= r_count - CNT_W'(1);
                        r_nres      <= r_nres + NRES_W'(1);
                        r_have_pend <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dl         <= r_time + TIME_W'(i_req.delay_ticks);
            r_new_handle <= i_req.handle[HB_ST-1:0];
            r_resp       <= (i_req.req_type == REQ_ARM && r_count == CNT_W'(CAPACITY))
                            ? ST_FULL : ST_ARMED;
        end
        if (r_state == S_POP && out_free && fire) begin
            r_pend <= head_handle;
        end
        if (out_load) begin
            r_out_status <= out_status;
            r_out_handle <= out_handle;
            r_out_last   <= out_last;
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.fired_handle = HANDLE_W'(r_out_handle);
    assign o_rsp.last         = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == REQ_TICK) |=> (r_time == $past(r_time) + TIME_W'(1)))
        else $error("tick did not advance the time count");

    a_search_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH || r_state == S_INSERT) |-> (r_ptr <= r_count))
        else $error("insert position beyond the filled entries");

    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_FIRED) |-> (r_out_handle == '0))
        else $error("handle reported on a result that fired nothing");

endmodule

`default_nettype wire

// ----- rtl/core/dtq_store.sv -----
// Sorted store of pending deadlines with insert-shift and pop-shift.
`timescale 1ns / 1ps
`default_nettype none

module dtq_store (
    input  wire logic                        i_clk,
    input  wire dtq_pkg::t_store_ctl         i_ctl,
    input  wire logic [dtq_pkg::TIME_W-1:0]  i_deadline,
    input  wire logic [dtq_pkg::HB_ST-1:0]   i_handle,
    output logic      [dtq_pkg::TIME_W-1:0]  o_head_deadline,
    output logic      [dtq_pkg::HB_ST-1:0]   o_head_handle,
    output logic      [dtq_pkg::TIME_W-1:0]  o_rd_deadline
);
    import dtq_pkg::*;

    logic [TIME_W-1:0] r_deadline [CAPACITY];
    logic [HB_ST-1:0]  r_handle   [CAPACITY];

    // Insert moves slots above pos up one; pop moves all but the last down one.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_ctl.ins) begin
                if (CNT_W'(i) == i_ctl.pos) begin
                    r_deadline[i] <= i_deadline;
                    r_handle[i]   <= i_handle;
                end else if ((i > 0) && (CNT_W'(i) > i_ctl.pos)) begin
                    r_deadline[i] <= r_deadline[(i > 0) ? i - 1 : 0];
                    r_handle[i]   <= r_handle[(i > 0) ? i - 1 : 0];
                end
            end else if (i_ctl.pop && (i < CAPACITY - 1)) begin
                r_deadline[i] <= r_deadline[(i < CAPACITY - 1) ? i + 1 : i];
                r_handle[i]   <= r_handle[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    assign o_head_deadline = r_deadline[0];
    assign o_head_handle   = r_handle[0];
    assign o_rd_deadline   = r_deadline[i_ctl.rd_idx];

endmodule

`default_nettype wire

// ----- tb/tb_deadline_timer_queue.sv -----
// Self-checking testbench of the deadline timer queue: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_deadline_timer_queue;
    import dtq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_CYCLES     = 40;
    localparam int RANDOM_ITEMS   = 355;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] fired_handle;
        logic                last;
    } timer_rsp_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dtq_req_if req_if ();
    dtq_rsp_if rsp_if ();

    deadline_timer_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Own copy of the timer state: a sorted list of pending deadlines.
    logic [TIME_W-1:0]   tick_now;
    logic [TIME_W-1:0]   pend_deadline [CAPACITY];
    logic [HANDLE_W-1:0] pend_handle   [CAPACITY];
    int                  pend_cnt;

    timer_rsp_t awaited_rsp [$];

    int n_errors;
    int n_items, n_arms, n_ticks, n_fired, n_full, n_none_due;
    int quiet_cycles;
    bit tx_idle, rx_idle;
    int unsigned rsp_wait;
    int unsigned rsp_stall;
    timer_rsp_t  oldest;

    // Wrap-aware: a is at or before b when (b - a) has its top bit clear.
    function automatic bit due_by(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = b - a;
        return diff[TIME_W-1] == 1'b0;
    endfunction

    task automatic push_rsp(input t_status st, input logic [HANDLE_W-1:0] h, input logic lst);
        timer_rsp_t r;
        r.status       = st;
        r.fired_handle = h;
        r.last         = lst;
        awaited_rsp.push_back(r);
    endtask

    task automatic schedule_request(input logic rt, input logic [DELAY_W-1:0] dly,
                                    input logic [HANDLE_W-1:0] h);
        logic [TIME_W-1:0]   dl;
        logic [HANDLE_W-1:0] hm;
        int pos;
        int k;
        hm = h & HANDLE_W'((1 << HANDLE_BITS) - 1);
        if (rt == REQ_ARM) begin
            n_arms++;
            if (pend_cnt >= CAPACITY) begin
                n_full++;
                push_rsp(ST_FULL, '0, 1'b1);
            end else begin
                dl  = tick_now + TIME_W'(dly);
                pos = 0;
                while (pos < pend_cnt && due_by(pend_deadline[pos], dl))
                    pos++;
                for (int i = pend_cnt; i > pos; i--) begin
                    pend_deadline[i] = pend_deadline[i-1];
                    pend_handle[i]   = pend_handle[i-1];
                end
                pend_deadline[pos] = dl;
                pend_handle[pos]   = hm;
                pend_cnt++;
                push_rsp(ST_ARMED, '0, 1'b1);
            end
        end else begin
            n_ticks++;
            tick_now = tick_now + 1;
            k = 0;
            while (k < pend_cnt && k < MAX_RESULTS && due_by(pend_deadline[k], tick_now))
                k++;
            if (k == 0) begin
                n_none_due++;
                push_rsp(ST_NONE_DUE, '0, 1'b1);
            end else begin
                for (int i = 0; i < k; i++)
                    push_rsp(ST_FIRED, pend_handle[i], i == k - 1);
                for (int i = 0; i + k < pend_cnt; i++) begin
                    pend_deadline[i] = pend_deadline[i+k];
                    pend_handle[i]   = pend_handle[i+k];
                end
                pend_cnt -= k;
                n_fired  += k;
            end
        end
    endtask

    // Leaves valid high after the handshake so that a back-to-back item needs no toggle.
    task automatic send_req(input logic rt, input logic [DELAY_W-1:0] dly,
                            input logic [HANDLE_W-1:0] h);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            if (req_if.valid === 1'b1)
                req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= rt;
        req_if.delay_ticks <= dly;
        req_if.handle      <= h;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        schedule_request(rt, dly, h);
        n_items++;
    endtask

    task automatic release_req();
        if (req_if.valid === 1'b1)
            req_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        release_req();
        do @(posedge i_clk); while (awaited_rsp.size() != 0);
    endtask

    // Two entries armed with zero delay share a deadline and must leave in arrival order.
    task automatic test_equal_deadlines();
        send_req(REQ_ARM, 16'h0000, 8'h00);
        send_req(REQ_ARM, 16'h0000, 8'hFF);
        send_req(REQ_TICK, 16'h0000, 8'h00);
        send_req(REQ_TICK, 16'hFFFF, 8'hFF);
    endtask

    // Fill the store, get one rejection, then let all sixteen entries fire on one tick.
    task automatic test_store_full();
        for (int i = 0; i < CAPACITY; i++)
            send_req(REQ_ARM, 16'd2, HANDLE_W'($urandom_range(0, 255)));
        send_req(REQ_ARM, 16'd1, 8'h3C);
        send_req(REQ_TICK, 16'd0, 8'd0);
        send_req(REQ_TICK, 16'd0, 8'd0);
    endtask

    // The longest delay never comes due in this run and stays at the back of the store.
    task automatic test_long_delay();
        send_req(REQ_ARM, 16'hFFFF, 8'hA5);
        send_req(REQ_TICK, 16'd0, 8'd0);
    endtask

    task automatic test_random_traffic(input int n_target);
        int start;
        int burst;
        logic [DELAY_W-1:0] dly;
        start = n_items;
        while (n_items - start < n_target) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(0, 99) < 85)
                    dly = DELAY_W'($urandom_range(0, 15));
                else
                    dly = DELAY_W'($urandom_range(16, 100));
                send_req(REQ_ARM, dly, HANDLE_W'($urandom_range(0, 255)));
            end
            burst = $urandom_range(1, 10);
            for (int i = 0; i < burst; i++)
                send_req(REQ_TICK, DELAY_W'($urandom), HANDLE_W'($urandom));
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (awaited_rsp.size() == 0) begin
                $error("result with no request behind it: status %0d, handle %0d",
                       rsp_if.status, rsp_if.fired_handle);
                n_errors++;
            end else begin
                oldest = awaited_rsp.pop_front();
                if (rsp_if.status !== oldest.status) begin
                    $error("status: expected %0d, got %0d", oldest.status, rsp_if.status);
                    n_errors++;
                end
                if (rsp_if.fired_handle !== oldest.fired_handle) begin
                    $error("fired_handle: expected %0d, got %0d",
                           oldest.fired_handle, rsp_if.fired_handle);
                    n_errors++;
                end
                if (rsp_if.last !== oldest.last) begin
                    $error("last: expected %0d, got %0d", oldest.last, rsp_if.last);
                    n_errors++;
                end
            end
            rsp_stall = rx_idle ? $urandom_range(0, 15) : 0;
            if (rsp_stall != 0) begin
                rsp_if.ready <= 1'b0;
                rsp_wait     <= rsp_stall - 1;
            end
        end else if (rsp_if.ready !== 1'b1) begin
            if (rsp_wait == 0)
                rsp_if.ready <= 1'b1;
            else
                rsp_wait <= rsp_wait - 1;
        end
    end

    // Results that nobody awaits do not count as progress, so a runaway output cannot
    // keep the run alive.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1 && awaited_rsp.size() != 0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no item moved for %0d cycles, %0d results still awaited",
                   quiet_cycles, awaited_rsp.size());
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_ARM;
        req_if.delay_ticks = '0;
        req_if.handle      = '0;
        rsp_if.ready       = 1'b0;
        rsp_wait           = 0;
        quiet_cycles       = 0;
        tick_now           = '0;
        pend_cnt           = 0;
        n_errors           = 0;
        n_items            = 0;
        n_arms             = 0;
        n_ticks            = 0;
        n_fired            = 0;
        n_full             = 0;
        n_none_due         = 0;
        tx_idle            = 1'b0;
        rx_idle            = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_equal_deadlines();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        test_store_full();
        wait_drained();
        test_long_delay();
        test_random_traffic(RANDOM_ITEMS);

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests: %0d arms (%0d rejected, store full), %0d ticks.",
                 n_items, n_arms, n_full, n_ticks);
        $display("Ticks fired %0d entries; %0d ticks found nothing due; %0d errors.",
                 n_fired, n_none_due, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
